[rtl/core/fct_pkg.sv]
`timescale 1ns / 1ps

package fct_pkg;

   // Plane register file geometry.
   localparam int PLANE_REGS     = 6;
   localparam int PLANE_BITS     = 64;
   localparam int CSR_INDEX_BITS = 3;

   // Field layout of one plane word: a, b, c in Q1.14, d in coordinate units.
   localparam int COEF_BITS = 16;
   localparam int A_LSB     = 0;
   localparam int B_LSB     = 16;
   localparam int C_LSB     = 32;
   localparam int D_LSB     = 48;

   // Fixed widths of the request fields.
   localparam int MODE_BITS = 2;
   localparam int HALF_BITS = 15;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_POINT = 2'd0,
      MODE_CUBE  = 2'd1,
      MODE_BOX   = 2'd2,
      MODE_UNDEF = 2'd3
   } mode_type;

   typedef logic [PLANE_BITS-1:0] plane_word_type;

   // Load enables of the pipeline stages behind the input register.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

[rtl/core/fct_if.sv]
`timescale 1ns / 1ps

// Request channel: one point, cube or box per item.
interface fct_req_if import fct_pkg::*; #(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic [MODE_BITS-1:0]         mode;
   logic signed [COORD_BITS-1:0] x_low;
   logic signed [COORD_BITS-1:0] y_low;
   logic signed [COORD_BITS-1:0] z_low;
   logic signed [COORD_BITS-1:0] x_high;
   logic signed [COORD_BITS-1:0] y_high;
   logic signed [COORD_BITS-1:0] z_high;
   logic [HALF_BITS-1:0]         half_size;

   modport source (output valid, mode, x_low, y_low, z_low, x_high, y_high, z_high,
                   half_size, input ready);
   modport sink (input valid, mode, x_low, y_low, z_low, x_high, y_high, z_high,
                 half_size, output ready);
endinterface

// Response channel: one visibility flag per item.
interface fct_rsp_if ();
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

// Register write channel.
interface fct_csr_if import fct_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [PLANE_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/frustum_cull_test.sv]
`timescale 1ns / 1ps
// An item passes the input register, then the corner, product, pass and
// output registers. Throughput: one item per cycle; every stage holds one
// item and moves on when the stage behind it is empty or moving, so the
// flow is bounded only by response backpressure. Reset (synchronous, active
// high) empties the pipeline and clears all six plane registers to zero.
module frustum_cull_test import fct_pkg::*; #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14,
   parameter int PLANE_COUNT      = 6
) (
   input logic       clock,
   input logic       reset,
   fct_req_if.sink   req_ch,
   fct_rsp_if.source rsp_ch,
   fct_csr_if.sink   csr_ch
);

   localparam int EXT_BITS = ((COORD_BITS > HALF_BITS + 1) ? COORD_BITS : HALF_BITS + 1) + 1;

   plane_word_type [PLANE_REGS-1:0] planes;

   logic                         v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic                         en0, en4;
   stage_en_type                 en;

   mode_type                     mode0_ff, mode1_ff, mode2_ff, mode3_ff;
   logic signed [COORD_BITS-1:0] x_low_ff, y_low_ff, z_low_ff;
   logic signed [COORD_BITS-1:0] x_high_ff, y_high_ff, z_high_ff;
   logic [HALF_BITS-1:0]         half_ff;

   logic signed [EXT_BITS-1:0]   lo [3];
   logic signed [EXT_BITS-1:0]   hi [3];
   logic [PLANE_COUNT-1:0]       pass;
   logic                         strict;
   logic                         visible_in;
   logic                         visible_ff;

   fct_plane_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .planes (planes)
   );

   // A stage loads when it is empty or the stage behind it loads.
   always_comb begin
      en4   = !v4_ff || rsp_ch.ready;
      en.s3 = !v3_ff || en4;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;
      en0   = !v0_ff || en.s1;
   end

   assign req_ch.ready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en0) begin
            v0_ff <= req_ch.valid;
         end
         if (en.s1) begin
            v1_ff <= v0_ff;
         end
         if (en.s2) begin
            v2_ff <= v1_ff;
         end
         if (en.s3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (en0) begin
         mode0_ff  <= mode_type'(req_ch.mode);
         x_low_ff  <= req_ch.x_low;
         y_low_ff  <= req_ch.y_low;
         z_low_ff  <= req_ch.z_low;
         x_high_ff <= req_ch.x_high;
         y_high_ff <= req_ch.y_high;
         z_high_ff <= req_ch.z_high;
         half_ff   <= req_ch.half_size;
      end
   end

   // The mode follows its item down the pipeline.
   always_ff @(posedge clock) begin
      if (en.s1) begin
         mode1_ff <= mode0_ff;
      end
      if (en.s2) begin
         mode2_ff <= mode1_ff;
      end
      if (en.s3) begin
         mode3_ff <= mode2_ff;
      end
   end

   fct_corner #(
      .COORD_BITS (COORD_BITS),
      .EXT_BITS   (EXT_BITS)
   ) u_corner (
      .clock     (clock),
      .load      (en.s1),
      .mode      (mode0_ff),
      .x_low     (x_low_ff),
      .y_low     (y_low_ff),
      .z_low     (z_low_ff),
      .x_high    (x_high_ff),
      .y_high    (y_high_ff),
      .z_high    (z_high_ff),
      .half_size (half_ff),
      .lo_out    (lo),
      .hi_out    (hi)
   );

   // Box corners on a plane count as inside; points and cubes must be past it.
   assign strict = (mode2_ff != MODE_BOX);

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fct_plane_eval #(
         .EXT_BITS         (EXT_BITS),
         .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
      ) u_eval (
         .clock  (clock),
         .en     (en),
         .plane  (planes[p]),
         .lo     (lo),
         .hi     (hi),
         .strict (strict),
         .pass   (pass[p])
      );
   end

   // Visible only if every tested plane passes and the mode is defined.
   assign visible_in = (mode3_ff != MODE_UNDEF) && (&pass);

   always_ff @(posedge clock) begin
      if (en4) begin
         visible_ff <= visible_in;
      end
   end

   assign rsp_ch.valid   = v4_ff;
   assign rsp_ch.visible = visible_ff;

endmodule

[rtl/core/fct_plane_regs.sv]
`timescale 1ns / 1ps

module fct_plane_regs import fct_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   fct_csr_if.sink                         csr_ch,
   output plane_word_type [PLANE_REGS-1:0] planes
);

   plane_word_type [PLANE_REGS-1:0] plane_ff;

   // Writes are always taken; indexes past the last plane are dropped.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (csr_ch.valid &&
                   (int'(csr_ch.index) < PLANE_REGS)) begin
         plane_ff[csr_ch.index] <= csr_ch.data;
      end
   end

   assign planes = plane_ff;

endmodule

[rtl/core/fct_corner.sv]
`timescale 1ns / 1ps

module fct_corner import fct_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int EXT_BITS   = 17
) (
   input  logic                         clock,
   input  logic                         load,
   input  mode_type                     mode,
   input  logic signed [COORD_BITS-1:0] x_low,
   input  logic signed [COORD_BITS-1:0] y_low,
   input  logic signed [COORD_BITS-1:0] z_low,
   input  logic signed [COORD_BITS-1:0] x_high,
   input  logic signed [COORD_BITS-1:0] y_high,
   input  logic signed [COORD_BITS-1:0] z_high,
   input  logic [HALF_BITS-1:0]         half_size,
   output logic signed [EXT_BITS-1:0]   lo_out [3],
   output logic signed [EXT_BITS-1:0]   hi_out [3]
);

   logic signed [EXT_BITS-1:0] base [3];
   logic signed [EXT_BITS-1:0] top  [3];
   logic signed [EXT_BITS-1:0] half;
   logic signed [EXT_BITS-1:0] lo_in [3];
   logic signed [EXT_BITS-1:0] hi_in [3];
   logic signed [EXT_BITS-1:0] lo_ff [3];
   logic signed [EXT_BITS-1:0] hi_ff [3];

   // Widen the coordinates so that center plus or minus half never wraps.
   always_comb begin
      base[0] = EXT_BITS'(x_low);
      base[1] = EXT_BITS'(y_low);
      base[2] = EXT_BITS'(z_low);
      top[0]  = EXT_BITS'(x_high);
      top[1]  = EXT_BITS'(y_high);
      top[2]  = EXT_BITS'(z_high);
      half    = EXT_BITS'(half_size);
   end

   // A point is a degenerate box; a cube spans center +/- half.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (mode)
            MODE_CUBE: begin
               lo_in[k] = base[k] - half;
               hi_in[k] = base[k] + half;
            end
            MODE_BOX: begin
               lo_in[k] = base[k];
               hi_in[k] = top[k];
            end
            default: begin
               lo_in[k] = base[k];
               hi_in[k] = base[k];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign lo_out = lo_ff;
   assign hi_out = hi_ff;

endmodule

[rtl/core/fct_plane_eval.sv]
`timescale 1ns / 1ps

module fct_plane_eval import fct_pkg::*; #(
   parameter int EXT_BITS         = 17,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                       clock,
   input  stage_en_type               en,
   input  plane_word_type             plane,
   input  logic signed [EXT_BITS-1:0] lo [3],
   input  logic signed [EXT_BITS-1:0] hi [3],
   input  logic                       strict,
   output logic                       pass
);

   localparam int PROD_BITS = COEF_BITS + EXT_BITS;
   localparam int D_BITS    = COEF_BITS + NORMAL_FRAC_BITS;
   localparam int SUM_BITS  = ((PROD_BITS > D_BITS) ? PROD_BITS : D_BITS) + 2;

   logic signed [COEF_BITS-1:0] coef [3];
   logic signed [COEF_BITS-1:0] d_coef;
   logic signed [EXT_BITS-1:0]  pick [3];
   logic signed [PROD_BITS-1:0] prod_in [3];
   logic signed [PROD_BITS-1:0] prod_ff [3];
   logic signed [COEF_BITS-1:0] d_ff;
   logic signed [SUM_BITS-1:0]  dist_sum;
   logic                        pass_in;
   logic                        pass_ff;

   always_comb begin
      coef[0] = plane[A_LSB +: COEF_BITS];
      coef[1] = plane[B_LSB +: COEF_BITS];
      coef[2] = plane[C_LSB +: COEF_BITS];
      d_coef  = plane[D_LSB +: COEF_BITS];
   end

   // Per axis, take the coordinate that maximizes the term: the largest
   // distance over the eight corners is the sum of these maxima.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (coef[k][COEF_BITS-1]) begin
            pick[k] = (hi[k] < lo[k]) ? hi[k] : lo[k];
         end else begin
            pick[k] = (hi[k] > lo[k]) ? hi[k] : lo[k];
         end
         prod_in[k] = PROD_BITS'(coef[k]) * PROD_BITS'(pick[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         prod_ff <= prod_in;
         d_ff    <= d_coef;
      end
   end

   // Exact signed distance, offset aligned to the product scale.
   always_comb begin
      dist_sum = SUM_BITS'(prod_ff[0]) + SUM_BITS'(prod_ff[1]) + SUM_BITS'(prod_ff[2])
                 + (SUM_BITS'(d_ff) <<< NORMAL_FRAC_BITS);
      if (strict) begin
         pass_in = !dist_sum[SUM_BITS-1] && (dist_sum != '0);
      end else begin
         pass_in = !dist_sum[SUM_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         pass_ff <= pass_in;
      end
   end

   assign pass = pass_ff;

endmodule
